[design/rpe_pkg.sv]
package rpe_pkg;

    // Characters the parser reacts to.
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Status codes on the terminating beat.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_PARAM_INDEX = 1'b0;
    localparam logic CFG_OUT_SIZE    = 1'b1;

    // Reset value of the output capacity register.
    localparam logic [6:0] OUT_SIZE_RESET = 7'd64;

    // Saturation limit of the 7-bit byte counters.
    localparam logic [6:0] SAT7 = 7'd127;

    // One decided line, passed from the parser to the emitter.
    typedef struct packed {
        logic       bank;
        logic [5:0] len;
        logic [1:0] status;
    } t_job;

    // Emitter tells the parser that a buffer bank is free again.
    typedef struct packed {
        logic vld;
        logic bank;
    } t_rel;

endpackage

[design/rpe_if.sv]
// Input channel: one byte of a response line per beat.
interface rpe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       line_end;

    modport source (output valid, output line_byte, output line_end, input ready);
    modport sink (input valid, input line_byte, input line_end, output ready);
endinterface

// Output channel: one parameter character or the terminator per beat.
interface rpe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic [5:0] param_length;
    logic [1:0] status;
    logic       run_last;

    modport source (output valid, output out_char, output param_length, output status,
                    output run_last, input ready);
    modport sink (input valid, input out_char, input param_length, input status,
                  input run_last, output ready);
endinterface

[design/rpe_front.sv]
module rpe_front #(
    parameter int PARAM_DEPTH = 64,
    localparam int AW = $clog2(PARAM_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rpe_in_if.sink           line_ch,
    input  logic [7:0]       i_param_index,
    input  logic [6:0]       i_out_size,
    input  logic             i_q_full,
    input  rpe_pkg::t_rel    i_rel,
    output logic             o_push,
    output rpe_pkg::t_job    o_job,
    output logic             o_wr_en,
    output logic             o_wr_bank,
    output logic [AW-1:0]    o_wr_addr,
    output logic [7:0]       o_wr_data
);
    import rpe_pkg::*;

    localparam int CAP = (PARAM_DEPTH < 64) ? PARAM_DEPTH : 64;

    localparam logic [1:0] PH_SEEK  = 2'd0;
    localparam logic [1:0] PH_SKIP  = 2'd1;
    localparam logic [1:0] PH_PARAM = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_field, n_field;
    logic       r_inq, n_inq;
    logic [6:0] r_raw, n_raw;
    logic [6:0] r_trim, n_trim;
    logic       r_bank, n_bank;
    logic [1:0] r_busy, n_busy;

    logic       fire;
    logic       push;
    t_job       job;
    logic       wr_en;

    // A byte is taken while the job queue has room and the fill bank is free.
    assign line_ch.ready = !i_q_full && !r_busy[r_bank];
    assign fire = line_ch.valid && line_ch.ready;

    // Per-byte parse step.
    always_comb begin
        logic [7:0] c;
        logic       last;
        logic       is_term;
        logic       do_param;
        logic       sel;
        logic       append;
        logic       eol;
        logic       extract;
        logic       nf;
        logic [6:0] raw_app;
        logic       too_long;

        c        = line_ch.line_byte;
        last     = line_ch.line_end;
        is_term  = (c == CH_CR) || (c == CH_LF);
        do_param = 1'b0;
        sel      = (r_field == i_param_index);
        append   = 1'b0;
        eol      = 1'b0;
        extract  = 1'b0;
        nf       = 1'b0;
        raw_app  = (r_raw < SAT7) ? r_raw + 7'd1 : r_raw;
        too_long = 1'b0;

        n_phase = r_phase;
        n_field = r_field;
        n_inq   = r_inq;
        n_raw   = r_raw;
        n_trim  = r_trim;
        n_bank  = r_bank;
        n_busy  = r_busy;
        job     = '0;
        push    = 1'b0;
        wr_en   = 1'b0;

        case (r_phase)
            PH_SEEK: begin
                if (c == CH_COLON) begin
                    n_phase = PH_SKIP;
                    nf      = last;
                end else if (is_term || last) begin
                    nf = 1'b1;
                end
            end
            PH_SKIP: begin
                if (c == CH_SPACE) begin
                    nf = last;
                end else begin
                    n_phase  = PH_PARAM;
                    do_param = 1'b1;
                end
            end
            PH_PARAM: begin
                do_param = 1'b1;
            end
            default: begin
            end
        endcase

        // Parameter list: quotes toggle, unquoted commas count fields.
        if (do_param) begin
            if (c == CH_QUOTE) begin
                n_inq  = !r_inq;
                append = sel;
                eol    = last;
            end else if (is_term || (c == CH_NUL)) begin
                eol = 1'b1;
            end else if ((c == CH_COMMA) && !r_inq) begin
                if (sel) begin
                    extract = 1'b1;
                end else begin
                    n_field = r_field + 8'd1;
                    n_phase = PH_SKIP;
                    nf      = last;
                end
            end else begin
                append = sel;
                eol    = last;
            end
        end

        // Buffer a byte of the selected parameter.
        if (append) begin
            n_raw = raw_app;
            if (c != CH_SPACE) begin
                n_trim = raw_app;
            end
            wr_en = ({2'b00, r_raw} < 9'(PARAM_DEPTH));
        end

        // End of the list decides between the parameter and not found.
        if (eol) begin
            if (sel && (n_raw != 7'd0)) begin
                extract = 1'b1;
            end else begin
                nf = 1'b1;
            end
        end

        too_long = (i_out_size == 7'd0) || (n_trim >= i_out_size) || (n_trim >= 7'(CAP));

        if (extract) begin
            push       = 1'b1;
            n_phase    = PH_DONE;
            job.bank   = r_bank;
            if (too_long) begin
                job.status = ST_TOO_LONG;
            end else begin
                job.status = ST_OK;
                job.len    = n_trim[5:0];
            end
        end else if (nf) begin
            push       = 1'b1;
            n_phase    = PH_DONE;
            job.status = ST_NOT_FOUND;
        end

        // A run with characters holds its bank until the emitter drains it.
        if (push && (job.len != 6'd0)) begin
            n_bank         = !r_bank;
            n_busy[r_bank] = 1'b1;
        end

        // The final byte starts the next line from scratch.
        if (last) begin
            n_phase = PH_SEEK;
            n_field = 8'd0;
            n_inq   = 1'b0;
            n_raw   = 7'd0;
            n_trim  = 7'd0;
        end
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK;
            r_field <= 8'd0;
            r_inq   <= 1'b0;
            r_raw   <= 7'd0;
            r_trim  <= 7'd0;
            r_bank  <= 1'b0;
            r_busy  <= 2'b00;
        end else begin
            if (fire) begin
                r_phase <= n_phase;
                r_field <= n_field;
                r_inq   <= n_inq;
                r_raw   <= n_raw;
                r_trim  <= n_trim;
                r_bank  <= n_bank;
            end
            r_busy <= (fire ? n_busy : r_busy) &
                      ~((i_rel.vld ? 2'b01 : 2'b00) << i_rel.bank);
        end
    end

    assign o_push    = fire && push;
    assign o_job     = job;
    assign o_wr_en   = fire && wr_en;
    assign o_wr_bank = r_bank;
    assign o_wr_addr = AW'(r_raw);
    assign o_wr_data = line_ch.line_byte;

endmodule

[design/rpe_queue.sv]
module rpe_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rpe_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output rpe_pkg::t_job o_job
);
    import rpe_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    // Two-entry job queue between parser and emitter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

[design/rpe_back.sv]
module rpe_back #(
    parameter int PARAM_DEPTH = 64,
    localparam int AW = $clog2(PARAM_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic          i_wr_bank,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_q_valid,
    input  rpe_pkg::t_job i_q_job,
    output logic          o_pop,
    output rpe_pkg::t_rel o_rel,
    rpe_out_if.source     param_ch
);
    import rpe_pkg::*;

    // Two banks of parameter bytes: one filling, one draining.
    logic [7:0] r_mem [2 << AW];
    logic [7:0] r_rdata;

    t_job       r_act;
    logic       r_act_v;
    logic [5:0] r_idx;

    logic       r_ov;
    logic       r_o_term;
    logic [5:0] r_o_len;
    logic [1:0] r_o_status;

    t_job       cur;
    logic [5:0] cur_idx;
    logic       have;
    logic       advance;
    logic       go;
    logic       is_char;

    // Current run is the active one, or else the queue head starting now.
    always_comb begin
        cur     = r_act_v ? r_act : i_q_job;
        cur_idx = r_act_v ? r_idx : 6'd0;
        have    = r_act_v || i_q_valid;
        advance = !r_ov || param_ch.ready;
        go      = advance && have;
        is_char = (cur_idx < cur.len);
    end

    assign o_pop     = go && !r_act_v;
    assign o_rel.vld  = go && !is_char && (cur.len != 6'd0);
    assign o_rel.bank = cur.bank;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[{i_wr_bank, i_wr_addr}] <= i_wr_data;
        end
        if (go && is_char) begin
            r_rdata <= r_mem[{cur.bank, AW'(cur_idx)}];
        end
    end

    // Run sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_v <= 1'b0;
            r_ov    <= 1'b0;
        end else if (go) begin
            r_ov <= 1'b1;
            if (is_char) begin
                r_act_v <= 1'b1;
            end else begin
                r_act_v <= 1'b0;
            end
        end else if (advance) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_act      <= cur;
            r_idx      <= cur_idx + 6'd1;
            r_o_term   <= !is_char;
            r_o_len    <= cur.len;
            r_o_status <= cur.status;
        end
    end

    assign param_ch.valid        = r_ov;
    assign param_ch.out_char     = r_o_term ? CH_NUL : r_rdata;
    assign param_ch.param_length = r_o_term ? r_o_len : 6'd0;
    assign param_ch.status       = r_o_term ? r_o_status : ST_OK;
    assign param_ch.run_last     = r_o_term;

endmodule

[design/response_parameter_extractor.sv]
// Extracts one comma-separated parameter after the first colon of a response line
// and returns it as a run of character beats closed by a terminator beat that carries
// the trimmed length and a status (ok, not found, too long). Unless stalled, the parser
// takes one line byte per cycle; while the output is ready, the emitter sends one beat
// per cycle, back to back across runs, with the registered buffer read hidden in the
// output register. A run reaches the output through the job queue and output register.
// Two buffer banks alternate between runs that carry characters. Input stalls, from
// the byte after such a run is decided, for as long as both banks still hold runs not
// yet delivered, and also while the two-entry job queue is full. The buffer needs no
// clearing after reset.
module response_parameter_extractor #(
    parameter int PARAM_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    rpe_in_if.sink     i_line,
    rpe_out_if.source  o_param
);
    import rpe_pkg::*;

    localparam int AW = $clog2(PARAM_DEPTH);

    logic [7:0]    r_param_index;
    logic [6:0]    r_out_size;

    logic          q_full;
    logic          q_valid;
    logic          push;
    logic          pop;
    t_job          push_job;
    t_job          head_job;
    t_rel          rel;
    logic          wr_en;
    logic          wr_bank;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_param_index <= 8'd0;
            r_out_size    <= OUT_SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PARAM_INDEX: r_param_index <= i_cfg_data;
                CFG_OUT_SIZE:    r_out_size    <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    rpe_front #(.PARAM_DEPTH(PARAM_DEPTH)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .line_ch       (i_line),
        .i_param_index (r_param_index),
        .i_out_size    (r_out_size),
        .i_q_full      (q_full),
        .i_rel         (rel),
        .o_push        (push),
        .o_job         (push_job),
        .o_wr_en       (wr_en),
        .o_wr_bank     (wr_bank),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data)
    );

    rpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    rpe_back #(.PARAM_DEPTH(PARAM_DEPTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_bank (wr_bank),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_q_valid (q_valid),
        .i_q_job   (head_job),
        .o_pop     (pop),
        .o_rel     (rel),
        .param_ch  (o_param)
    );

endmodule

[design/rpe_check.sv]
module rpe_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [7:0] i_out_char,
    input logic [5:0] i_param_length,
    input logic [1:0] i_status,
    input logic       i_run_last
);
    import rpe_pkg::*;

    // A stalled beat stays and keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid &&
        $stable({i_out_char, i_param_length, i_status, i_run_last}))
        else $error("output beat changed while stalled");

    // The terminator carries a zero character.
    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_run_last |-> i_out_char == CH_NUL)
        else $error("terminator with nonzero character");

    // Character beats carry no length and no status.
    a_char_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_run_last |-> i_status == ST_OK && i_param_length == 6'd0)
        else $error("character beat with length or status");

    // A failed run reports a known status and no length.
    a_fail_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_run_last && i_status != ST_OK |->
        i_param_length == 6'd0 && (i_status == ST_NOT_FOUND || i_status == ST_TOO_LONG))
        else $error("bad status or length on failed run");

endmodule

bind response_parameter_extractor rpe_check u_rpe_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_param.valid),
    .i_ready        (o_param.ready),
    .i_out_char     (o_param.out_char),
    .i_param_length (o_param.param_length),
    .i_status       (o_param.status),
    .i_run_last     (o_param.run_last)
);

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import rpe_pkg::*;

    localparam int PARAM_DEPTH   = 64;
    localparam int STORE_CAP     = (PARAM_DEPTH < 64) ? PARAM_DEPTH : 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int IDLE_PCT      = 12;

    typedef enum logic [1:0] {SEEK_COLON, SKIP_SPACES, IN_PARAM, LINE_DONE} t_parse_phase;

    typedef struct packed {
        logic [7:0] out_char;
        logic [5:0] param_length;
        logic [1:0] status;
        logic       run_last;
    } t_param_beat;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic       i_cfg_idx  = CFG_PARAM_INDEX;
    logic [7:0] i_cfg_data = 8'h00;

    rpe_in_if  line_if();
    rpe_out_if param_if();

    response_parameter_extractor #(.PARAM_DEPTH(PARAM_DEPTH)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_line     (line_if),
        .o_param    (param_if)
    );

    // Parser state of the line in flight, kept by the predictor.
    t_parse_phase phase     = SEEK_COLON;
    logic [7:0]   field_cnt = 8'd0;
    logic         in_quotes = 1'b0;
    logic [7:0]   param_buf [0:PARAM_DEPTH-1];
    logic [6:0]   raw_cnt   = 7'd0;
    logic [6:0]   trim_end  = 7'd0;

    // Register values as the block should hold them.
    logic [7:0] cfg_param_index = 8'd0;
    logic [6:0] cfg_out_size    = OUT_SIZE_RESET;

    t_param_beat due_beats[$];
    logic [7:0]  line_q[$];
    int          fail_count  = 0;
    int          bytes_sent  = 0;
    int          idle_cycles = 0;
    bit          steady_flow = 1'b0;

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void queue_beat(input logic [7:0] ch, input logic [5:0] len,
                                       input logic [1:0] st, input logic last);
        t_param_beat b;
        b.out_char     = ch;
        b.param_length = len;
        b.status       = st;
        b.run_last     = last;
        due_beats.push_back(b);
    endfunction

    function automatic void decide_not_found();
        phase = LINE_DONE;
        queue_beat(CH_NUL, 6'd0, ST_NOT_FOUND, 1'b1);
    endfunction

    // The selected parameter is complete: emit it, or report it as too long.
    function automatic void decide_param();
        phase = LINE_DONE;
        if (cfg_out_size == 0 || trim_end >= cfg_out_size || trim_end >= STORE_CAP) begin
            queue_beat(CH_NUL, 6'd0, ST_TOO_LONG, 1'b1);
        end else begin
            for (int i = 0; i < trim_end; i++)
                queue_beat(param_buf[i], 6'd0, ST_OK, 1'b0);
            queue_beat(CH_NUL, trim_end[5:0], ST_OK, 1'b1);
        end
    endfunction

    // An empty final parameter counts as missing, unlike one closed by a comma.
    function automatic void decide_at_list_end();
        if (field_cnt == cfg_param_index && raw_cnt > 0)
            decide_param();
        else
            decide_not_found();
    endfunction

    function automatic void buffer_char(input logic [7:0] c);
        if (raw_cnt < PARAM_DEPTH)
            param_buf[raw_cnt] = c;
        if (raw_cnt < SAT7)
            raw_cnt = raw_cnt + 7'd1;
        if (c != CH_SPACE)
            trim_end = raw_cnt;
    endfunction

    function automatic void parse_line_byte(input logic [7:0] c, input logic last);
        logic in_list;
        logic check_end;
        in_list   = 1'b0;
        check_end = 1'b0;
        case (phase)
            SEEK_COLON: begin
                if (c == CH_COLON) begin
                    phase = SKIP_SPACES;
                    if (last)
                        decide_not_found();
                end else if (c == CH_CR || c == CH_LF || last) begin
                    decide_not_found();
                end
            end
            SKIP_SPACES: begin
                if (c == CH_SPACE) begin
                    if (last)
                        decide_not_found();
                end else begin
                    phase   = IN_PARAM;
                    in_list = 1'b1;
                end
            end
            IN_PARAM: in_list = 1'b1;
            default: ;
        endcase

        // Inside the parameter list: quotes, terminators and field separators.
        if (in_list) begin
            if (c == CH_QUOTE) begin
                in_quotes = !in_quotes;
                if (field_cnt == cfg_param_index)
                    buffer_char(c);
                check_end = 1'b1;
            end else if (c == CH_CR || c == CH_LF || c == CH_NUL) begin
                decide_at_list_end();
            end else if (c == CH_COMMA && !in_quotes) begin
                if (field_cnt == cfg_param_index) begin
                    decide_param();
                end else begin
                    field_cnt = field_cnt + 8'd1;
                    phase     = SKIP_SPACES;
                    if (last)
                        decide_not_found();
                end
            end else begin
                if (field_cnt == cfg_param_index)
                    buffer_char(c);
                check_end = 1'b1;
            end
            if (check_end && last)
                decide_at_list_end();
        end

        // The final byte starts a fresh line; registers are kept.
        if (last) begin
            phase     = SEEK_COLON;
            field_cnt = 8'd0;
            in_quotes = 1'b0;
            raw_cnt   = 7'd0;
            trim_end  = 7'd0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Output side: random back-pressure and beat checking
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        param_if.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_param_beat want;
        if (i_rst_n && param_if.valid && param_if.ready) begin
            if (due_beats.size() == 0) begin
                $error("unexpected beat: out_char=%0h param_length=%0d status=%0d run_last=%0b",
                       param_if.out_char, param_if.param_length, param_if.status,
                       param_if.run_last);
                fail_count++;
            end else begin
                want = due_beats.pop_front();
                if (param_if.out_char !== want.out_char) begin
                    $error("out_char: expected %0h, got %0h", want.out_char, param_if.out_char);
                    fail_count++;
                end
                if (param_if.param_length !== want.param_length) begin
                    $error("param_length: expected %0d, got %0d",
                           want.param_length, param_if.param_length);
                    fail_count++;
                end
                if (param_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, param_if.status);
                    fail_count++;
                end
                if (param_if.run_last !== want.run_last) begin
                    $error("run_last: expected %0b, got %0b", want.run_last, param_if.run_last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too many cycles without any beat on either channel.
    always @(posedge i_clk) begin
        if ((line_if.valid && line_if.ready) || (param_if.valid && param_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_byte(input logic [7:0] b, input logic e);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            line_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        line_if.valid     <= 1'b1;
        line_if.line_byte <= b;
        line_if.line_end  <= e;
        @(posedge i_clk);
        while (!line_if.ready)
            @(posedge i_clk);
        parse_line_byte(b, e);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_q.size(); i++)
            send_byte(line_q[i], i == line_q.size() - 1);
        line_q.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endtask

    task automatic add_fill(input logic [7:0] ch, input int n);
        repeat (n) line_q.push_back(ch);
    endtask

    task automatic send_text(input string s);
        add_text(s);
        send_line();
    endtask

    // Stop sending, let every pending run drain and the parser go quiet.
    task automatic settle();
        line_if.valid <= 1'b0;
        while (due_beats.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_PARAM_INDEX)
            cfg_param_index = data;
        else
            cfg_out_size = data[6:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [7:0] index, input logic [7:0] size);
        settle();
        write_reg(CFG_PARAM_INDEX, index);
        write_reg(CFG_OUT_SIZE, size);
    endtask

    // ------------------------------------------------------------------
    // Random line generation
    // ------------------------------------------------------------------

    function automatic logic [7:0] random_param_char(input logic quoted);
        int         r;
        logic [7:0] c;
        r = $urandom_range(9);
        if (r < 2)
            return CH_SPACE;
        if (r == 2 && quoted)
            return CH_COMMA;
        c = 8'($urandom_range(8'h21, 8'hFF));
        if (c == CH_COMMA || c == CH_QUOTE)
            c = "x";
        return c;
    endfunction

    task automatic add_random_param(input int max_len);
        int   n;
        logic quoted;
        n      = ($urandom_range(19) == 0) ? $urandom_range(70) : $urandom_range(max_len);
        quoted = ($urandom_range(3) == 0);
        if (quoted)
            line_q.push_back(CH_QUOTE);
        repeat (n) line_q.push_back(random_param_char(quoted));
        // A quote is sometimes left open, which hides the commas after it.
        if (quoted && $urandom_range(7) != 0)
            line_q.push_back(CH_QUOTE);
    endtask

    task automatic send_random_line(input int max_len);
        int kind;
        int nparams;
        int keep;
        kind = $urandom_range(99);
        if (kind < 15) begin
            // Noise: arbitrary bytes.
            repeat ($urandom_range(1, 16)) line_q.push_back(8'($urandom_range(255)));
        end else begin
            add_text("+R");
            repeat ($urandom_range(3)) line_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
            line_q.push_back(CH_COLON);
            add_fill(CH_SPACE, $urandom_range(2));
            nparams = $urandom_range(1, 5);
            for (int p = 0; p < nparams; p++) begin
                if (p > 0) begin
                    line_q.push_back(CH_COMMA);
                    add_fill(CH_SPACE, $urandom_range(1));
                end
                add_random_param(max_len);
            end
            case ($urandom_range(3))
                0: ;
                1: begin
                    line_q.push_back(CH_CR);
                    line_q.push_back(CH_LF);
                end
                2: line_q.push_back(CH_LF);
                default: begin
                    line_q.push_back(CH_NUL);
                    repeat ($urandom_range(3)) line_q.push_back(8'($urandom_range(255)));
                end
            endcase
            // Broken line: cut short at a random point.
            if (kind < 25) begin
                keep = $urandom_range(1, line_q.size());
                while (line_q.size() > keep)
                    void'(line_q.pop_back());
            end
        end
        send_line();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers at their reset values: index 0, capacity 64.
    task automatic test_reset_values();
        add_text("+CSQ: 23,99");
        line_q.push_back(CH_CR);
        line_q.push_back(CH_LF);
        send_line();
        // No colon before CR.
        add_text("OK");
        line_q.push_back(CH_CR);
        line_q.push_back(CH_LF);
        send_line();
        // Line ends without any colon.
        send_text("ABC");
        // Nothing after the colon.
        send_text(":");
        send_text("X:   ");
        add_text("X: ");
        line_q.push_back(CH_CR);
        send_line();
    endtask

    task automatic test_special_cases();
        // Comma inside quotes is part of the text; trailing space is trimmed.
        send_text("X:\"a,b\" ,c");
        // CR inside quotes still ends the list.
        add_text("X:\"a");
        line_q.push_back(CH_CR);
        add_text("b\"");
        send_line();
        // NUL ends the list; the rest of the line is ignored.
        add_text("X:ab");
        line_q.push_back(CH_NUL);
        add_text("c");
        send_line();
        // Empty parameter closed by a comma.
        send_text(":,x");
        send_text("+X: abc   ");
        send_text(": a  b  ,z");
        // Bytes with the top bit set, and one just below.
        add_text(":");
        line_q.push_back(8'hFF);
        line_q.push_back(8'h80);
        line_q.push_back(8'h7F);
        send_line();
    endtask

    task automatic test_param_select();
        configure(8'd2, 8'd64);
        add_text("+R: 1, 2,  three  ,4");
        line_q.push_back(CH_LF);
        send_line();
        send_text("+R: 1,2");
        send_text("+R: 1,2,");
        // Empty final parameter.
        add_text("+R: 1,2,");
        line_q.push_back(CH_CR);
        send_line();
        // Highest index: a short list never reaches it.
        configure(8'd255, 8'd64);
        send_text(":a,b");
    endtask

    task automatic test_size_limits();
        configure(8'd0, 8'd4);
        send_text(":abc");
        send_text(":abcd");
        configure(8'd0, 8'd0);
        send_text(":a");
        send_text(":,");
        configure(8'd0, 8'd1);
        send_text(":,");
        send_text(":a");
        // Capacity above the buffer: the buffer depth is the limit.
        configure(8'd0, 8'd127);
        add_text(":");
        add_fill("b", 64);
        send_line();
    endtask

    task automatic random_phase(input logic [7:0] index, input logic [7:0] size,
                                input int max_len, input int n_bytes);
        int start;
        configure(index, size);
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
            send_random_line(max_len);
    endtask

    task automatic test_random_traffic();
        random_phase(8'd0, 8'd64, 8, 12);
        random_phase(8'd1, 8'd8, 10, 12);
        // A stretch with both sides running flat out.
        steady_flow = 1'b1;
        random_phase(8'd2, 8'($urandom_range(1, 64)), 6, 12);
        steady_flow = 1'b0;
        random_phase(8'($urandom_range(3)), 8'($urandom_range(127)), 8, 12);
    endtask

    initial begin
        line_if.valid     = 1'b0;
        line_if.line_byte = 8'h00;
        line_if.line_end  = 1'b0;
        param_if.ready    = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_special_cases();
        test_param_select();
        test_size_limits();
        test_random_traffic();

        settle();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
